// ===== hdl/lesf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared constants and helpers for the largest empty square finder.
// ----------------------------------------------------------------------------
package lesf_pkg;

    localparam int MAX_COLS_DEFAULT = 1024;
    localparam int MAX_ROWS_DEFAULT = 1024;

    // Field widths fixed by the interface
    localparam int CELL_W   = 8;
    localparam int SIZE_W   = 11;
    localparam int COORD_W  = 10;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int M_DATA_W = 32;

    localparam logic [CELL_W-1:0] OBSTACLE_RESET = 8'd111;
    localparam logic [CFG_W-1:0]  WIDTH_RESET    = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OBSTACLE = 2'd0,
        CFG_WIDTH    = 2'd1
    } cfg_index_t;

endpackage

// ===== hdl/largest_empty_square_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// Streams map cells in raster order and reports the largest all-free square.
// ----------------------------------------------------------------------------
// Takes one map cell per cycle when not stalled. Each cell goes through two
// stages: the first counts row and column and reads the previous row's
// square size for that column from a single-port-read, single-port-write
// line memory; the second forms a free cell's size as one plus the minimum
// of above, left and up-left (0 for an obstacle), writes it back and updates
// the best square. A same-column write and read in one cycle (one-column
// maps) is forwarded. The tlast word's result is registered from stage 2 for
// the master side; that word waits only while an untaken result is held.
// Results pack square_size, top_row, left_col from bit 0; no free cell gives
// size 0 at row 0, column 0. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module largest_empty_square_finder #(
    parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write port
    input  logic                            cfg_we,
    input  logic [lesf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lesf_pkg::CFG_W-1:0]      cfg_data,
    // cell stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lesf_pkg::CELL_W-1:0]     s_axis_tdata,   // [7:0] cell_byte
    input  logic                            s_axis_tlast,   // last_cell
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [10:0] square_size, [20:11] top_row, [30:21] left_col, [31] zero
    output logic [lesf_pkg::M_DATA_W-1:0]   m_axis_tdata
);

    localparam int COL_IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW1    = $clog2(MAX_COLS + 1);
    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int SW     = CW1;

    // configuration
    logic [lesf_pkg::CELL_W-1:0] obstacle_reg;
    logic [lesf_pkg::CFG_W-1:0]  width_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obstacle_reg  <= lesf_pkg::OBSTACLE_RESET;
            width_cfg_reg <= lesf_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (lesf_pkg::cfg_index_t'(cfg_index))
                lesf_pkg::CFG_OBSTACLE: obstacle_reg  <= cfg_data[lesf_pkg::CELL_W-1:0];
                lesf_pkg::CFG_WIDTH:    width_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [CW1-1:0] width_act;

    always_comb
    begin
        if (width_cfg_reg == '0)
            width_act = CW1'(1);
        else if (32'(width_cfg_reg) > MAX_COLS)
            width_act = CW1'(MAX_COLS);
        else
            width_act = CW1'(width_cfg_reg);
    end

    // stage 1: position counters and line memory read
    logic [COL_IW-1:0] scan_col_reg, scan_col_next;
    logic [ROW_CW-1:0] scan_row_reg, scan_row_next;
    logic              accept;
    logic              a_in_range;
    logic              a_wrap;

    // stage 2 registers
    logic              b_valid_reg;
    logic              b_in_range_reg;
    logic              b_wrap_reg;
    logic              b_last_reg;
    logic              b_free_reg;
    logic [COL_IW-1:0] b_col_reg;
    logic [ROW_IW-1:0] b_row_reg;
    logic [SW-1:0]     up_rd_reg;
    logic              fwd_reg;
    logic [SW-1:0]     fwd_val_reg;

    logic              b_stall;
    logic              b_fire;
    logic [SW-1:0]     s_val;

    logic [SW-1:0]     line_mem [MAX_COLS];

    logic              out_valid_reg;

    assign b_stall       = b_valid_reg && b_last_reg && out_valid_reg && !m_axis_tready;
    assign b_fire        = b_valid_reg && !b_stall;
    assign s_axis_tready = !b_stall;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign a_in_range = 32'(scan_row_reg) < MAX_ROWS;
    assign a_wrap     = (CW1'(scan_col_reg) + CW1'(1)) >= width_act;

    always_comb
    begin
        scan_col_next = scan_col_reg;
        scan_row_next = scan_row_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                scan_col_next = '0;
                scan_row_next = '0;
            end
            else if (a_in_range)
            begin
                if (a_wrap)
                begin
                    scan_col_next = '0;
                    scan_row_next = scan_row_reg + ROW_CW'(1);
                end
                else
                begin
                    scan_col_next = scan_col_reg + COL_IW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_col_reg <= '0;
            scan_row_reg <= '0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            scan_col_reg <= scan_col_next;
            scan_row_reg <= scan_row_next;
            if (!b_stall)
                b_valid_reg <= accept;
        end
    end

    // stage 2 payload; forward a write landing on the column read this cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_in_range_reg <= a_in_range;
            b_wrap_reg     <= a_wrap;
            b_last_reg     <= s_axis_tlast;
            b_free_reg     <= s_axis_tdata != obstacle_reg;
            b_col_reg      <= scan_col_reg;
            b_row_reg      <= ROW_IW'(scan_row_reg);
            fwd_reg        <= b_fire && b_in_range_reg && (b_col_reg == scan_col_reg);
            fwd_val_reg    <= s_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            up_rd_reg <= line_mem[scan_col_reg];
        if (b_fire && b_in_range_reg)
            line_mem[b_col_reg] <= s_val;
    end

    // stage 2: square size update
    logic [SW-1:0]     left_reg, diag_reg;
    logic [SW-1:0]     best_size_reg, best_size_next;
    logic [ROW_IW-1:0] best_row_reg, best_row_next;
    logic [COL_IW-1:0] best_col_reg, best_col_next;
    logic [SW-1:0]     up_val, left_val, diag_val, min_val;

    always_comb
    begin
        up_val   = (b_row_reg != '0) ? (fwd_reg ? fwd_val_reg : up_rd_reg) : '0;
        left_val = (b_col_reg != '0) ? left_reg : '0;
        diag_val = (b_col_reg != '0 && b_row_reg != '0) ? diag_reg : '0;
        min_val  = (up_val < left_val) ? up_val : left_val;
        if (diag_val < min_val)
            min_val = diag_val;
        s_val = b_free_reg ? (min_val + SW'(1)) : '0;

        best_size_next = best_size_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        if (b_in_range_reg && (s_val > best_size_reg))
        begin
            best_size_next = s_val;
            best_row_next  = ROW_IW'(32'(b_row_reg) + 32'd1 - 32'(s_val));
            best_col_next  = COL_IW'(32'(b_col_reg) + 32'd1 - 32'(s_val));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end
        else if (b_fire)
        begin
            if (b_last_reg)
            begin
                // restart for the next map
                left_reg      <= '0;
                diag_reg      <= '0;
                best_size_reg <= '0;
                best_row_reg  <= '0;
                best_col_reg  <= '0;
            end
            else
            begin
                if (b_in_range_reg)
                begin
                    left_reg <= b_wrap_reg ? '0 : s_val;
                    diag_reg <= b_wrap_reg ? '0 : up_val;
                end
                best_size_reg <= best_size_next;
                best_row_reg  <= best_row_next;
                best_col_reg  <= best_col_next;
            end
        end
    end

    // result register
    logic [lesf_pkg::SIZE_W-1:0]  out_size_reg;
    logic [lesf_pkg::COORD_W-1:0] out_row_reg;
    logic [lesf_pkg::COORD_W-1:0] out_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (b_fire && b_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (b_fire && b_last_reg)
        begin
            out_size_reg <= lesf_pkg::SIZE_W'(best_size_next);
            out_row_reg  <= lesf_pkg::COORD_W'(best_row_next);
            out_col_reg  <= lesf_pkg::COORD_W'(best_col_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_col_reg, out_row_reg, out_size_reg};

endmodule
